// File: src/clipped_glyph_blit_unit_assert.svh
// Assertion macros used by the blit unit back end (cgb_back).
`ifndef CLIPPED_GLYPH_BLIT_UNIT_ASSERT_SVH
`define CLIPPED_GLYPH_BLIT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cgb_pkg.sv
package cgb_pkg;

    // Frame geometry
    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int GLYPH_MAX = 32;
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Field widths
    localparam int SIZE_W    = 6;
    localparam int POS_W     = 7;
    localparam int SUM_W     = 8;
    localparam int RC_W      = 5;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [SIZE_W-1:0] FRAME_ROWS_RST = SIZE_W'(32);
    localparam logic [SIZE_W-1:0] FRAME_COLS_RST = SIZE_W'(32);

    // Queue between front and back (depth is a power of two)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS = 1'b0,
        CFG_FRAME_COLS = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MOP_NONE  = 2'd0,
        MOP_WRITE = 2'd1,
        MOP_READ  = 2'd2
    } t_mem_op;

    // One classified transaction, front to back
    typedef struct packed {
        t_mem_op           op;
        logic [ADDR_W-1:0] addr;
        logic              wdata;
        logic              written;
        logic              done;
        logic              dirty;
    } t_blit_op;

endpackage

// File: src/clipped_glyph_blit_unit.sv
// Channel | Direction | Handshake                  | Payload
// cfg     | in        | i_cfg_we                   | i_cfg_index, i_cfg_wdata
// in      | in        | i_in_valid / o_in_ready    | request fields i_req_type .. i_read_col
// out     | out       | o_out_valid / i_out_ready  | o_read_pixel, o_pixel_written,
//         |           |                            | o_glyph_done, o_dirty
//
// One transaction per cycle sustained while i_out_ready stays high. The front
// classifies a transaction in its accept cycle. o_out_valid then rises after the queue
// slot, the access stage (registered frame store read) and the output register.
// After reset the frame store is swept to zero over 1024 addresses, one bit per cycle;
// o_in_ready is low for that time, configuration writes are taken throughout.
// A 4-entry queue between front and back absorbs output stalls; o_in_ready drops
// only when that queue is full or the clearing sweep runs.
module clipped_glyph_blit_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cgb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cgb_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cgb_pkg::REQ_W-1:0]        i_req_type,
    input  logic signed [cgb_pkg::POS_W-1:0] i_place_row,
    input  logic signed [cgb_pkg::POS_W-1:0] i_place_col,
    input  logic [cgb_pkg::SIZE_W-1:0]       i_glyph_rows,
    input  logic [cgb_pkg::SIZE_W-1:0]       i_glyph_cols,
    input  logic                             i_pixel_value,
    input  logic [cgb_pkg::RC_W-1:0]         i_read_row,
    input  logic [cgb_pkg::RC_W-1:0]         i_read_col,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_read_pixel,
    output logic                             o_pixel_written,
    output logic                             o_glyph_done,
    output logic                             o_dirty
);

    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    logic              clearing;
    cgb_pkg::t_blit_op push_op;
    cgb_pkg::t_blit_op head;

    cgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_place_row  (i_place_row),
        .i_place_col  (i_place_col),
        .i_glyph_rows (i_glyph_rows),
        .i_glyph_cols (i_glyph_cols),
        .i_pixel_value(i_pixel_value),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_q_full     (q_full),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_push_op    (push_op)
    );

    cgb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_push_op(push_op),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_empty  (q_empty),
        .o_head   (head)
    );

    cgb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_pixel   (o_read_pixel),
        .o_pixel_written(o_pixel_written),
        .o_glyph_done   (o_glyph_done),
        .o_dirty        (o_dirty)
    );

endmodule

// File: src/cgb_front.sv
module cgb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cgb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cgb_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cgb_pkg::REQ_W-1:0]     i_req_type,
    input  logic signed [cgb_pkg::POS_W-1:0] i_place_row,
    input  logic signed [cgb_pkg::POS_W-1:0] i_place_col,
    input  logic [cgb_pkg::SIZE_W-1:0]    i_glyph_rows,
    input  logic [cgb_pkg::SIZE_W-1:0]    i_glyph_cols,
    input  logic                          i_pixel_value,
    input  logic [cgb_pkg::RC_W-1:0]      i_read_row,
    input  logic [cgb_pkg::RC_W-1:0]      i_read_col,
    input  logic                          i_q_full,
    input  logic                          i_clearing,
    output logic                          o_push,
    output cgb_pkg::t_blit_op             o_push_op
);

    logic [cgb_pkg::SIZE_W-1:0] r_frame_rows;
    logic [cgb_pkg::SIZE_W-1:0] r_frame_cols;
    logic [cgb_pkg::POS_W-1:0]  r_org_row, n_org_row;
    logic [cgb_pkg::POS_W-1:0]  r_org_col, n_org_col;
    logic [cgb_pkg::SIZE_W-1:0] r_glyph_h, n_glyph_h;
    logic [cgb_pkg::SIZE_W-1:0] r_glyph_w, n_glyph_w;
    logic [cgb_pkg::SIZE_W-1:0] r_cur_row, n_cur_row;
    logic [cgb_pkg::SIZE_W-1:0] r_cur_col, n_cur_col;
    logic                       r_placing, n_placing;
    logic                       r_dirty, n_dirty;

    logic                       accept;
    logic [cgb_pkg::POS_W-1:0]  fr, fc;
    logic signed [cgb_pkg::SUM_W-1:0] fr_s, fc_s;
    logic signed [cgb_pkg::SUM_W-1:0] beg_row, beg_col, beg_h, beg_w;
    logic signed [cgb_pkg::SUM_W-1:0] pix_row, pix_col;
    logic [cgb_pkg::SIZE_W-1:0] gh_clamp, gw_clamp;
    logic [cgb_pkg::SIZE_W-1:0] col_inc, row_inc;
    logic                       pix_inside, rd_inside;
    cgb_pkg::t_blit_op          op;

    assign o_in_ready = !i_q_full && !i_clearing;
    assign accept     = i_in_valid && o_in_ready;

    // Clamp frame size to 1..MAX
    always_comb begin
        if (r_frame_rows == '0) begin
            fr = cgb_pkg::POS_W'(1);
        end else if ({1'b0, r_frame_rows} > cgb_pkg::POS_W'(cgb_pkg::MAX_ROWS)) begin
            fr = cgb_pkg::POS_W'(cgb_pkg::MAX_ROWS);
        end else begin
            fr = {1'b0, r_frame_rows};
        end
        if (r_frame_cols == '0) begin
            fc = cgb_pkg::POS_W'(1);
        end else if ({1'b0, r_frame_cols} > cgb_pkg::POS_W'(cgb_pkg::MAX_COLS)) begin
            fc = cgb_pkg::POS_W'(cgb_pkg::MAX_COLS);
        end else begin
            fc = {1'b0, r_frame_cols};
        end
        fr_s = $signed({1'b0, fr});
        fc_s = $signed({1'b0, fc});
    end

    // Clamp glyph size to 1..GLYPH_MAX
    always_comb begin
        if (i_glyph_rows == '0) begin
            gh_clamp = cgb_pkg::SIZE_W'(1);
        end else if (i_glyph_rows > cgb_pkg::SIZE_W'(cgb_pkg::GLYPH_MAX)) begin
            gh_clamp = cgb_pkg::SIZE_W'(cgb_pkg::GLYPH_MAX);
        end else begin
            gh_clamp = i_glyph_rows;
        end
        if (i_glyph_cols == '0) begin
            gw_clamp = cgb_pkg::SIZE_W'(1);
        end else if (i_glyph_cols > cgb_pkg::SIZE_W'(cgb_pkg::GLYPH_MAX)) begin
            gw_clamp = cgb_pkg::SIZE_W'(cgb_pkg::GLYPH_MAX);
        end else begin
            gw_clamp = i_glyph_cols;
        end
    end

    // Target positions for begin overlap test and for the current pixel
    always_comb begin
        beg_row = $signed({i_place_row[cgb_pkg::POS_W-1], i_place_row});
        beg_col = $signed({i_place_col[cgb_pkg::POS_W-1], i_place_col});
        beg_h   = $signed({2'b00, gh_clamp});
        beg_w   = $signed({2'b00, gw_clamp});
        pix_row = $signed({r_org_row[cgb_pkg::POS_W-1], r_org_row})
                + $signed({2'b00, r_cur_row});
        pix_col = $signed({r_org_col[cgb_pkg::POS_W-1], r_org_col})
                + $signed({2'b00, r_cur_col});
        pix_inside = (pix_row >= 0) && (pix_row < fr_s)
                  && (pix_col >= 0) && (pix_col < fc_s);
        rd_inside  = ({2'b00, i_read_row} < fr) && ({2'b00, i_read_col} < fc);
        col_inc    = r_cur_col + cgb_pkg::SIZE_W'(1);
        row_inc    = r_cur_row + cgb_pkg::SIZE_W'(1);
    end

    // Classify the transaction and advance the placement state
    always_comb begin
        n_org_row = r_org_row;
        n_org_col = r_org_col;
        n_glyph_h = r_glyph_h;
        n_glyph_w = r_glyph_w;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_placing = r_placing;
        n_dirty   = r_dirty;
        op.op      = cgb_pkg::MOP_NONE;
        op.addr    = '0;
        op.wdata   = i_pixel_value;
        op.written = 1'b0;
        op.done    = 1'b0;
        unique case (cgb_pkg::t_req'(i_req_type))
            cgb_pkg::REQ_BEGIN: begin
                n_org_row = i_place_row;
                n_org_col = i_place_col;
                n_glyph_h = gh_clamp;
                n_glyph_w = gw_clamp;
                n_cur_row = '0;
                n_cur_col = '0;
                n_placing = 1'b1;
                if (!(beg_row >= fr_s || beg_col >= fc_s
                      || (beg_w + beg_col) <= 0 || (beg_h + beg_row) <= 0)) begin
                    n_dirty = 1'b1;
                end
            end
            cgb_pkg::REQ_PIXEL: begin
                if (r_placing) begin
                    if (pix_inside) begin
                        op.op      = cgb_pkg::MOP_WRITE;
                        op.addr    = cgb_pkg::ADDR_W'(
                                         32'(pix_row[cgb_pkg::SUM_W-2:0])
                                         * cgb_pkg::MAX_COLS
                                         + 32'(pix_col[cgb_pkg::SUM_W-2:0]));
                        op.written = 1'b1;
                    end
                    if (col_inc >= r_glyph_w) begin
                        n_cur_col = '0;
                        if (row_inc >= r_glyph_h) begin
                            n_cur_row = '0;
                            n_placing = 1'b0;
                            op.done   = 1'b1;
                        end else begin
                            n_cur_row = row_inc;
                        end
                    end else begin
                        n_cur_col = col_inc;
                    end
                end
            end
            cgb_pkg::REQ_READ: begin
                if (rd_inside) begin
                    op.op   = cgb_pkg::MOP_READ;
                    op.addr = cgb_pkg::ADDR_W'(32'(i_read_row) * cgb_pkg::MAX_COLS
                                               + 32'(i_read_col));
                end
            end
            default: begin
                // unused request code: result carries only dirty
            end
        endcase
        op.dirty = n_dirty;
    end

    assign o_push    = accept;
    assign o_push_op = op;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= cgb_pkg::FRAME_ROWS_RST;
            r_frame_cols <= cgb_pkg::FRAME_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (cgb_pkg::t_cfg_reg'(i_cfg_index))
                cgb_pkg::CFG_FRAME_ROWS: r_frame_rows <= i_cfg_wdata;
                cgb_pkg::CFG_FRAME_COLS: r_frame_cols <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Placement state, updated on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_row <= '0;
            r_org_col <= '0;
            r_glyph_h <= '0;
            r_glyph_w <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_placing <= 1'b0;
            r_dirty   <= 1'b0;
        end else if (accept) begin
            r_org_row <= n_org_row;
            r_org_col <= n_org_col;
            r_glyph_h <= n_glyph_h;
            r_glyph_w <= n_glyph_w;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_placing <= n_placing;
            r_dirty   <= n_dirty;
        end
    end

endmodule

// File: src/cgb_queue.sv
module cgb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cgb_pkg::t_blit_op i_push_op,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output cgb_pkg::t_blit_op o_head
);

    cgb_pkg::t_blit_op           r_slot [cgb_pkg::QDEPTH];
    logic [cgb_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [cgb_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [cgb_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == cgb_pkg::QCNT_W'(cgb_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cgb_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + cgb_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + cgb_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - cgb_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// File: src/cgb_back.sv
`include "clipped_glyph_blit_unit_assert.svh"

module cgb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  cgb_pkg::t_blit_op i_head,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_read_pixel,
    output logic              o_pixel_written,
    output logic              o_glyph_done,
    output logic              o_dirty
);

    logic                        r_mem [cgb_pkg::MEM_DEPTH];
    logic                        r_rdata;
    logic                        r_clr_busy;
    logic [cgb_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                        r_s1_valid;
    cgb_pkg::t_blit_op           r_s1;
    logic                        r_out_valid;
    logic                        r_out_read_pixel;
    logic                        r_out_written;
    logic                        r_out_done;
    logic                        r_out_dirty;

    logic                        s1_move;
    logic                        mem_we;
    logic [cgb_pkg::ADDR_W-1:0]  mem_waddr;
    logic                        mem_wdata;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_pop      = !i_q_empty && !r_clr_busy && (!r_s1_valid || s1_move);
    assign o_clearing = r_clr_busy;

    // Memory write port: clearing sweep or a popped pixel write
    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 1'b0;
        end else begin
            mem_we    = o_pop && (i_head.op == cgb_pkg::MOP_WRITE);
            mem_waddr = i_head.addr;
            mem_wdata = i_head.wdata;
        end
    end

    // Frame store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop && (i_head.op == cgb_pkg::MOP_READ)) begin
            r_rdata <= r_mem[i_head.addr];
        end
    end

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == cgb_pkg::ADDR_W'(cgb_pkg::MEM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + cgb_pkg::ADDR_W'(1);
            end
        end
    end

    // Access stage: hold the popped op while the memory read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_head;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_read_pixel <= (r_s1.op == cgb_pkg::MOP_READ) ? r_rdata : 1'b0;
            r_out_written    <= r_s1.written;
            r_out_done       <= r_s1.done;
            r_out_dirty      <= r_s1.dirty;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_pixel    = r_out_read_pixel;
    assign o_pixel_written = r_out_written;
    assign o_glyph_done    = r_out_done;
    assign o_dirty         = r_out_dirty;

    `CGB_ASSERT_NEXT(a_s1_hold, r_s1_valid && r_out_valid && !i_out_ready,
        r_s1_valid && $stable(r_s1), "access stage changed while output stalled")
    `CGB_ASSERT_NOW(a_clr_end, $fell(r_clr_busy),
        $past(r_clr_addr) == cgb_pkg::ADDR_W'(cgb_pkg::MEM_DEPTH - 1),
        "clearing pass ended before the last address")
    `CGB_ASSERT_NOW(a_clr_idle, r_clr_busy, !r_s1_valid && !r_out_valid,
        "transaction in flight during clearing pass")

endmodule
